// File: src/pattern_collapse_filter_top_macros.svh
// assertion macros for the pattern collapse filter
`ifndef PATTERN_COLLAPSE_FILTER_TOP_MACROS_SVH
`define PATTERN_COLLAPSE_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every edge outside reset
`define PCF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pattern collapse filter check failed");
// implication whose effect is checked in the cycle after the cause, outside reset
`define PCF_ASSERT_NEXT(label, clk, rst, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("pattern collapse filter sequence check failed");
`else
`define PCF_ASSERT(label, clk, rst, prop)
`define PCF_ASSERT_NEXT(label, clk, rst, cause, effect)
`endif
`endif

// File: src/pcf_pkg.sv
// shared constants and types of the pattern collapse filter
`default_nettype none

package pcf_pkg;

  localparam int NUM_CODES       = 7;
  localparam int MAX_PATTERN_DEF = 7;
  localparam int CODE_W          = 8;
  localparam int COUNT_W         = 16;
  localparam int LEN_W           = 3;
  localparam int SKIP_W          = 3;
  localparam int CFG_IDX_W       = 3;

  typedef logic signed [CODE_W-1:0] code_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic [SKIP_W-1:0]        skip_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam cfg_idx_t REG_PATTERN_LENGTH = 3'd0;
  localparam len_t     LEN_RESET          = 3'd7;
  localparam len_t     MIN_LEN            = 3'd2;

  typedef struct packed {
    code_t  code;
    logic   last;
    count_t total;
  } out_item_t;

endpackage

`default_nettype wire

// File: src/pattern_collapse_filter_top.sv
// pattern collapse filter: sliding pattern match with in-place substitution
//
// Codes enter on the in_valid/in_ready channel (code_in, final_in) and leave
// in stream order on out_valid/out_ready (code_out, final_out, match_total).
// The window is held back by pattern_length - 1 codes, so a request normally
// gives one result, the one leaving the window; the request with final_in set
// drains the window, one result per cycle, and the last result carries
// final_out and the saturating match count. Shortening pattern_length between
// streams makes the next request give several results, again one per cycle.
// A result passes through the input register and then the result queue. One
// window step per cycle (compare, collapse, shift) sets the rate: one code per
// cycle in the steady stream, one result per step while a window drains.
// Registers are written on cfg_valid/cfg_ready (always ready); the user must
// write only while idle, the block does not enforce it. A synchronous reset
// clears the window, counters, queues and registers. A receiver stall fills
// the two-entry result queue; the window step and the input register hold.
`default_nettype none
`include "pattern_collapse_filter_top_macros.svh"

module pattern_collapse_filter_top #(
  parameter int MAX_PATTERN = pcf_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire pcf_pkg::code_t          code_in,
  input  wire logic                    final_in,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      pcf_pkg::code_t          code_out,
  output      logic                    final_out,
  output      pcf_pkg::count_t         match_total,
  input  wire logic                    cfg_valid,
  output      logic                    cfg_ready,
  input  wire pcf_pkg::cfg_idx_t       cfg_index,
  input  wire pcf_pkg::code_t          cfg_data
);

  localparam int FILL_W  = $clog2(MAX_PATTERN + 1);
  localparam int LEN_CAP = (MAX_PATTERN < pcf_pkg::NUM_CODES) ? MAX_PATTERN
                                                              : pcf_pkg::NUM_CODES;

  // configuration
  pcf_pkg::len_t  plen;
  pcf_pkg::code_t pat [pcf_pkg::NUM_CODES];
  logic [FILL_W-1:0] len_act;
  logic [FILL_W-1:0] half;

  // input register
  logic           in_q_valid;
  pcf_pkg::code_t code_q;
  logic           fin_q;

  // window state
  pcf_pkg::code_t  win [MAX_PATTERN];
  logic [FILL_W-1:0] fill;
  pcf_pkg::skip_t  skip;
  pcf_pkg::count_t cnt;
  logic            flush_q;
  logic            run_q;

  pcf_pkg::code_t  win_next [MAX_PATTERN];
  logic [FILL_W-1:0] fill_next;
  pcf_pkg::skip_t  skip_next;
  pcf_pkg::count_t cnt_next;
  logic            flush_next;
  logic            run_next;

  // engine signals
  logic            out_space;
  logic            ins;
  logic            step;
  logic [FILL_W-1:0] ins_idx;
  pcf_pkg::code_t  win_a [MAX_PATTERN];
  logic [FILL_W-1:0] fill_a;
  logic            flush_a;
  pcf_pkg::code_t  win_b [MAX_PATTERN];
  pcf_pkg::code_t  win_s [MAX_PATTERN];
  pcf_pkg::code_t  win_p [MAX_PATTERN];
  pcf_pkg::skip_t  skip_b;
  pcf_pkg::count_t cnt_b;
  logic            found;
  pcf_pkg::skip_t  mis_k;
  pcf_pkg::code_t  sum;
  logic            do_eval;
  logic            do_flush;
  logic            emit;
  logic            emit_last;
  pcf_pkg::out_item_t emit_item;

  // result queue
  pcf_pkg::out_item_t ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] ocnt;
  logic       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= pcf_pkg::LEN_RESET;
      pat  <= '{default: '0};
    end else if (cfg_valid) begin
      if (cfg_index == pcf_pkg::REG_PATTERN_LENGTH) begin
        plen <= cfg_data[pcf_pkg::LEN_W-1:0];
      end else begin
        pat[cfg_index - pcf_pkg::cfg_idx_t'(1)] <= cfg_data;
      end
    end
  end

  always_comb begin
    priority if (plen < pcf_pkg::MIN_LEN) begin
      len_act = FILL_W'(pcf_pkg::MIN_LEN);
    end else if (int'(plen) > LEN_CAP) begin
      len_act = FILL_W'(LEN_CAP);
    end else begin
      len_act = FILL_W'(plen);
    end
  end

  assign half = len_act >> 1;

  // handshake: all terms are registered
  assign out_space = (ocnt != 2'd2);
  assign ins       = out_space && in_q_valid && !run_q;
  assign step      = out_space && (in_q_valid || run_q);
  assign in_ready  = !in_q_valid || ins;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (ins) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_q <= code_in;
      fin_q  <= final_in;
    end
  end

  // append the new code
  assign ins_idx = (fill >= FILL_W'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN - 1) : fill;

  always_comb begin
    win_a   = win;
    fill_a  = fill;
    flush_a = flush_q || (ins && fin_q);
    if (ins) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (FILL_W'(k) == ins_idx) begin
          win_a[k] = code_q;
        end
      end
      fill_a = ins_idx + FILL_W'(1);
    end
  end

  // compare against the pattern and form the collapsed sum
  always_comb begin
    found = 1'b0;
    mis_k = '0;
    sum   = '0;
    for (int k = 0; k < LEN_CAP; k++) begin
      if (FILL_W'(k) < len_act) begin
        sum = sum + win_a[k];
        if (!found && (win_a[k] != pat[k])) begin
          found = 1'b1;
          mis_k = pcf_pkg::SKIP_W'(k);
        end
      end
    end
  end

  always_comb begin
    win_b  = win_a;
    skip_b = skip;
    cnt_b  = cnt;
    if (skip != '0) begin
      skip_b = skip - pcf_pkg::skip_t'(1);
    end else if (found) begin
      skip_b = mis_k;
    end else begin
      for (int k = 0; k < LEN_CAP; k++) begin
        if (FILL_W'(k) < len_act) begin
          win_b[k] = (FILL_W'(k) == half) ? sum : '0;
        end
      end
      if (cnt != '1) begin
        cnt_b = cnt + pcf_pkg::count_t'(1);
      end
    end
  end

  assign do_eval   = step && (fill_a >= len_act);
  assign do_flush  = step && !do_eval && flush_a && (fill_a != '0);
  assign emit      = do_eval || do_flush;
  assign emit_last = do_flush && (fill_a == FILL_W'(1));

  always_comb begin
    win_s = do_eval ? win_b : win_a;
    for (int k = 0; k < MAX_PATTERN - 1; k++) begin
      win_p[k] = win_s[k + 1];
    end
    win_p[MAX_PATTERN - 1] = '0;
  end

  always_comb begin
    emit_item.code  = win_s[0];
    emit_item.last  = emit_last;
    emit_item.total = emit_last ? cnt : '0;
  end

  always_comb begin
    win_next   = win;
    fill_next  = fill;
    skip_next  = skip;
    cnt_next   = cnt;
    flush_next = flush_q;
    if (step) begin
      if (emit_last) begin
        win_next   = '{default: '0};
        fill_next  = '0;
        skip_next  = '0;
        cnt_next   = '0;
        flush_next = 1'b0;
      end else if (emit) begin
        win_next   = win_p;
        fill_next  = fill_a - FILL_W'(1);
        skip_next  = do_eval ? skip_b : skip;
        cnt_next   = do_eval ? cnt_b : cnt;
        flush_next = flush_a;
      end else begin
        win_next   = win_a;
        fill_next  = fill_a;
        flush_next = flush_a;
      end
    end
    // keep stepping while the window still owes results
    run_next = step ? ((fill_next >= len_act) || (flush_next && (fill_next != '0)))
                    : run_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= '{default: '0};
      fill    <= '0;
      skip    <= '0;
      cnt     <= '0;
      flush_q <= 1'b0;
      run_q   <= 1'b0;
    end else begin
      win     <= win_next;
      fill    <= fill_next;
      skip    <= skip_next;
      cnt     <= cnt_next;
      flush_q <= flush_next;
      run_q   <= run_next;
    end
  end

  // two-entry result queue
  assign out_valid = (ocnt != 2'd0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      ocnt   <= 2'd0;
    end else begin
      if (emit) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      ocnt <= ocnt + {1'b0, emit} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ent[wr_ptr] <= emit_item;
    end
  end

  assign code_out    = ent[rd_ptr].code;
  assign final_out   = ent[rd_ptr].last;
  assign match_total = ent[rd_ptr].total;

  `PCF_ASSERT(a_run_has_work, clk, rst,
              run_q |-> ((fill >= len_act) || (flush_q && (fill != '0))))
  `PCF_ASSERT(a_queue_no_overflow, clk, rst, (ocnt == 2'd2) |-> !emit)
  `PCF_ASSERT(a_queue_count_range, clk, rst, ocnt != 2'd3)
  `PCF_ASSERT_NEXT(a_last_clears_state, clk, rst, emit_last,
                   (fill == '0) && (cnt == '0) && (skip == '0) && !flush_q && !run_q)

endmodule

`default_nettype wire
